FILE: rtl/core/pp_proj_pkg.sv
// shared constants and types for the perspective point projection block
`timescale 1ns / 1ps
package pp_proj_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W           = 32;
    localparam int SIZE_W        = 14;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int VIS_SCALE     = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_AB  = 3'd0,
        REG_ROW0_CD  = 3'd1,
        REG_ROW1_AB  = 3'd2,
        REG_ROW1_CD  = 3'd3,
        REG_ROW3_AB  = 3'd4,
        REG_ROW3_CD  = 3'd5,
        REG_VIEW_W   = 3'd6,
        REG_VIEW_H   = 3'd7
    } cfg_index_t;

    localparam logic [SIZE_W-1:0] VIEW_W_RESET = 14'd1920;
    localparam logic [SIZE_W-1:0] VIEW_H_RESET = 14'd1080;

endpackage

FILE: rtl/core/perspective_point_projection.sv
// top level: matrix transform, pipelined divide and viewport mapping
//
// channel  | direction | payload
// s_       | in        | tdata: point_x, point_y, point_z
// m_       | out       | tdata: screen_x, screen_y, clip_w; tuser: visible
// cfg_     | in        | cfg_index, cfg_data (register write)
//
// one point per cycle sustained while the output is not stalled by m_tready
// stages in order: products, sums, prep, one divider stage per quotient bit, scale, output
// the divider is the longest part: one stage per bit of the 32 + FRAC_BITS quotient
// reset is synchronous, clears all valid bits and the matrix, and sets the viewport to 1920 x 1080
// each stage holds its item while the next is full, so a stall loses nothing
`timescale 1ns / 1ps
module perspective_point_projection
    import pp_proj_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [95:0]           s_tdata,   // point_x, point_y, point_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,   // screen_x, screen_y, clip_w
    output logic                  m_tuser,   // visible
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW  = Q_W + FRAC_BITS;
    localparam int PW  = 2 * Q_W;
    localparam int SW  = PW - FRAC_BITS + 2;
    localparam int TW  = DW + 1 + SIZE_W + 1;
    localparam int OW  = TW + 2;

    logic [CFG_DATA_W-1:0] coef_reg [6];
    logic [SIZE_W-1:0]     view_w_reg, view_h_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) coef_reg[i] <= '0;
            view_w_reg <= VIEW_W_RESET;
            view_h_reg <= VIEW_H_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                REG_ROW0_AB: coef_reg[0] <= cfg_data;
                REG_ROW0_CD: coef_reg[1] <= cfg_data;
                REG_ROW1_AB: coef_reg[2] <= cfg_data;
                REG_ROW1_CD: coef_reg[3] <= cfg_data;
                REG_ROW3_AB: coef_reg[4] <= cfg_data;
                REG_ROW3_CD: coef_reg[5] <= cfg_data;
                REG_VIEW_W:  view_w_reg  <= cfg_data[SIZE_W-1:0];
                REG_VIEW_H:  view_h_reg  <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // ready chain
    logic rdy_p, rdy_s, rdy_m, rdy_o;
    logic rdy_d [DW+1];
    logic vld_p_reg, vld_s_reg, vld_m_reg, vld_o_reg;
    logic vld_d_reg [DW+1];

    assign rdy_o    = !vld_o_reg || m_tready;
    assign rdy_m    = !vld_m_reg || rdy_o;
    assign rdy_d[DW] = !vld_d_reg[DW] || rdy_m;
    genvar g;
    generate
        for (g = 0; g < DW; g++) begin : g_rdy
            assign rdy_d[g] = !vld_d_reg[g] || rdy_d[g+1];
        end
    endgenerate
    assign rdy_s    = !vld_s_reg || rdy_d[0];
    assign rdy_p    = !vld_p_reg || rdy_s;
    assign s_tready = rdy_p;

    // product stage
    logic signed [Q_W-1:0] pt [3];
    logic signed [PW-1:0]  prod_next [9];
    logic signed [PW-1:0]  prod_reg  [9];
    logic signed [Q_W-1:0] trans_reg [3];

    assign pt[0] = $signed(s_tdata[31:0]);
    assign pt[1] = $signed(s_tdata[63:32]);
    assign pt[2] = $signed(s_tdata[95:64]);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            prod_next[3*r]   = $signed(coef_reg[2*r][63:32]) * pt[0];
            prod_next[3*r+1] = $signed(coef_reg[2*r][31:0]) * pt[1];
            prod_next[3*r+2] = $signed(coef_reg[2*r+1][63:32]) * pt[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_p_reg <= 1'b0;
        else if (rdy_p) vld_p_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (rdy_p && s_tvalid) begin
            prod_reg <= prod_next;
            for (int r = 0; r < 3; r++) trans_reg[r] <= $signed(coef_reg[2*r+1][31:0]);
        end
    end

    // sum and saturate stage
    logic signed [SW-1:0]  acc [3];
    logic signed [Q_W-1:0] clip_next [3];
    logic signed [Q_W-1:0] clip_reg  [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc[r] = SW'(prod_reg[3*r] >>> FRAC_BITS)
                   + SW'(prod_reg[3*r+1] >>> FRAC_BITS)
                   + SW'(prod_reg[3*r+2] >>> FRAC_BITS)
                   + SW'(trans_reg[r]);
            if (acc[r] > SW'($signed({1'b0, {(Q_W-1){1'b1}}})))
                clip_next[r] = {1'b0, {(Q_W-1){1'b1}}};
            else if (acc[r] < -(SW'(1) <<< (Q_W-1)))
                clip_next[r] = {1'b1, {(Q_W-1){1'b0}}};
            else
                clip_next[r] = acc[r][Q_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_s_reg <= 1'b0;
        else if (rdy_s) vld_s_reg <= vld_p_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy_s && vld_p_reg) clip_reg <= clip_next;
    end

    // divider stages, index 0 is the prep stage
    logic [DW-1:0]  numx_reg [DW+1];
    logic [DW-1:0]  numy_reg [DW+1];
    logic [Q_W-1:0] remx_reg [DW+1];
    logic [Q_W-1:0] remy_reg [DW+1];
    logic [Q_W-1:0] den_reg  [DW+1];
    logic [Q_W-1:0] cx_reg   [DW+1];
    logic [Q_W-1:0] cy_reg   [DW+1];
    logic [Q_W-1:0] w_reg    [DW+1];
    logic           negx_reg [DW+1];
    logic           negy_reg [DW+1];
    logic           vis_reg  [DW+1];

    logic signed [Q_W+8-1:0] w100;
    logic [Q_W-1:0]          absx, absy;

    assign w100 = (Q_W+8)'(clip_reg[2]) * (Q_W+8)'(VIS_SCALE);
    assign absx = clip_reg[0][Q_W-1] ? Q_W'(-clip_reg[0]) : clip_reg[0];
    assign absy = clip_reg[1][Q_W-1] ? Q_W'(-clip_reg[1]) : clip_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_d_reg[0] <= 1'b0;
        else if (rdy_d[0]) vld_d_reg[0] <= vld_s_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy_d[0] && vld_s_reg) begin
            numx_reg[0] <= {absx, {FRAC_BITS{1'b0}}};
            numy_reg[0] <= {absy, {FRAC_BITS{1'b0}}};
            remx_reg[0] <= '0;
            remy_reg[0] <= '0;
            den_reg[0]  <= clip_reg[2];
            cx_reg[0]   <= clip_reg[0];
            cy_reg[0]   <= clip_reg[1];
            w_reg[0]    <= clip_reg[2];
            negx_reg[0] <= clip_reg[0][Q_W-1];
            negy_reg[0] <= clip_reg[1][Q_W-1];
            vis_reg[0]  <= w100 >= ((Q_W+8)'(1) <<< FRAC_BITS);
        end
    end

    generate
        for (g = 1; g <= DW; g++) begin : g_div
            logic [Q_W:0]   rx, ry;
            logic [Q_W+1:0] dx, dy;
            assign rx = {remx_reg[g-1], numx_reg[g-1][DW-1]};
            assign ry = {remy_reg[g-1], numy_reg[g-1][DW-1]};
            assign dx = {1'b0, rx} - {2'b0, den_reg[g-1]};
            assign dy = {1'b0, ry} - {2'b0, den_reg[g-1]};

            always_ff @(posedge aclk) begin
                if (!aresetn) vld_d_reg[g] <= 1'b0;
                else if (rdy_d[g]) vld_d_reg[g] <= vld_d_reg[g-1];
            end

            always_ff @(posedge aclk) begin
                if (rdy_d[g] && vld_d_reg[g-1]) begin
                    numx_reg[g] <= {numx_reg[g-1][DW-2:0], !dx[Q_W+1]};
                    numy_reg[g] <= {numy_reg[g-1][DW-2:0], !dy[Q_W+1]};
                    remx_reg[g] <= dx[Q_W+1] ? rx[Q_W-1:0] : dx[Q_W-1:0];
                    remy_reg[g] <= dy[Q_W+1] ? ry[Q_W-1:0] : dy[Q_W-1:0];
                    den_reg[g]  <= den_reg[g-1];
                    cx_reg[g]   <= cx_reg[g-1];
                    cy_reg[g]   <= cy_reg[g-1];
                    w_reg[g]    <= w_reg[g-1];
                    negx_reg[g] <= negx_reg[g-1];
                    negy_reg[g] <= negy_reg[g-1];
                    vis_reg[g]  <= vis_reg[g-1];
                end
            end
        end
    endgenerate

    // scale stage
    logic signed [DW:0]   qx, qy;
    logic signed [TW-1:0] tx_reg, ty_reg;
    logic [Q_W-1:0]       mcx_reg, mcy_reg, mw_reg;
    logic                 mvis_reg;

    assign qx = negx_reg[DW] ? -$signed({1'b0, numx_reg[DW]}) : $signed({1'b0, numx_reg[DW]});
    assign qy = negy_reg[DW] ? -$signed({1'b0, numy_reg[DW]}) : $signed({1'b0, numy_reg[DW]});

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_m_reg <= 1'b0;
        else if (rdy_m) vld_m_reg <= vld_d_reg[DW];
    end

    always_ff @(posedge aclk) begin
        if (rdy_m && vld_d_reg[DW]) begin
            tx_reg   <= TW'(qx) * TW'($signed({1'b0, view_w_reg}));
            ty_reg   <= TW'(qy) * TW'($signed({1'b0, view_h_reg}));
            mcx_reg  <= cx_reg[DW];
            mcy_reg  <= cy_reg[DW];
            mw_reg   <= w_reg[DW];
            mvis_reg <= vis_reg[DW];
        end
    end

    // mapping and output stage
    logic signed [OW-1:0]  hx, hy, bx, by, sx, sy;
    logic signed [Q_W-1:0] sx_sat, sy_sat;
    logic [95:0]           out_data_reg;
    logic                  out_vis_reg;

    function automatic logic [Q_W-1:0] sat_q(input logic signed [OW-1:0] v);
        logic [Q_W-1:0] res;
        if (v > OW'($signed({1'b0, {(Q_W-1){1'b1}}})))
            res = {1'b0, {(Q_W-1){1'b1}}};
        else if (v < -(OW'(1) <<< (Q_W-1)))
            res = {1'b1, {(Q_W-1){1'b0}}};
        else
            res = v[Q_W-1:0];
        return res;
    endfunction

    always_comb begin
        hx = (OW'(tx_reg) + (OW'(1) <<< FRAC_BITS)) >>> 1;
        hy = (OW'(ty_reg) + (OW'(1) <<< FRAC_BITS)) >>> 1;
        bx = OW'({1'b0, view_w_reg[SIZE_W-1:1]}) <<< FRAC_BITS;
        by = OW'({1'b0, view_h_reg[SIZE_W-1:1]}) <<< FRAC_BITS;
        sx = bx + hx;
        sy = by - hy;
        sx_sat = sat_q(sx);
        sy_sat = sat_q(sy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_o_reg <= 1'b0;
        else if (rdy_o) vld_o_reg <= vld_m_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy_o && vld_m_reg) begin
            out_data_reg[31:0]  <= mvis_reg ? sx_sat : mcx_reg;
            out_data_reg[63:32] <= mvis_reg ? sy_sat : mcy_reg;
            out_data_reg[95:64] <= mw_reg;
            out_vis_reg         <= mvis_reg;
        end
    end

    assign m_tvalid = vld_o_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_vis_reg;

endmodule

FILE: rtl/core/pp_proj_checker.sv
// port-level checks for the perspective point projection block
`timescale 1ns / 1ps
module pp_proj_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // a stalled transfer keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // visible results need a positive w
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[95] && (m_tdata[95:64] != 32'd0))
        else $error("visible with non-positive w");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind perspective_point_projection pp_proj_checker u_pp_proj_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/perspective_point_projection_tb.sv
// self-checking testbench for the perspective point projection block
`timescale 1ns / 1ps
module perspective_point_projection_tb;
    import pp_proj_pkg::*;

    localparam int  FRAC       = FRAC_BITS_DEF;
    localparam int  IDLE_LIMIT = 5000;
    localparam int  DRAIN_WAIT = FRAC + 60;
    localparam longint ONE_Q   = longint'(1) <<< FRAC;
    localparam longint Q_HI    = 64'sd2147483647;
    localparam longint Q_LO    = -64'sd2147483648;

    typedef struct {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] w;
        logic        vis;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata = '0;   // point_x, point_y, point_z
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [95:0]           m_tdata;        // screen_x, screen_y, clip_w
    logic                  m_tuser;        // visible
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [63:0] row_coef [6];
    longint      view_w;
    longint      view_h;

    logic [95:0] pending_points [$];
    pixel_t      pending_pixels [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_count = 0;
    int          quiet_cycles = 0;

    perspective_point_projection dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint sat_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    function automatic longint row_sum(int r, longint px, longint py, longint pz);
        longint c0, c1, c2, c3;
        c0 = longint'($signed(row_coef[r][63:32]));
        c1 = longint'($signed(row_coef[r][31:0]));
        c2 = longint'($signed(row_coef[r+1][63:32]));
        c3 = longint'($signed(row_coef[r+1][31:0]));
        return sat_q(((c0 * px) >>> FRAC) + ((c1 * py) >>> FRAC)
                     + ((c2 * pz) >>> FRAC) + c3);
    endfunction

    function automatic longint half_span(longint c, longint w, longint size);
        longint n;
        n = (c * ONE_Q) / w;
        return (n * size + ONE_Q) >>> 1;
    endfunction

    function automatic pixel_t project_point(logic [95:0] d);
        pixel_t r;
        longint px, py, pz, cx, cy, w, sx, sy;
        px = longint'($signed(d[31:0]));
        py = longint'($signed(d[63:32]));
        pz = longint'($signed(d[95:64]));
        cx = row_sum(0, px, py, pz);
        cy = row_sum(2, px, py, pz);
        w  = row_sum(4, px, py, pz);
        sx = cx;
        sy = cy;
        r.vis = (w * VIS_SCALE) >= ONE_Q;
        if (r.vis) begin
            sx = sat_q((view_w >>> 1) * ONE_Q + half_span(cx, w, view_w));
            sy = sat_q((view_h >>> 1) * ONE_Q - half_span(cy, w, view_h));
        end
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.w  = w[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_points.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && s_tvalid && s_tready)
            pending_pixels.push_back(project_point(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("unexpected result transfer %h at %0t", m_tdata, $realtime);
                err_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[31:0] !== want.sx) report_mismatch("screen_x", m_tdata[31:0], want.sx);
                if (m_tdata[63:32] !== want.sy)
                    report_mismatch("screen_y", m_tdata[63:32], want.sy);
                if (m_tdata[95:64] !== want.w) report_mismatch("clip_w", m_tdata[95:64], want.w);
                if (m_tuser !== want.vis) report_mismatch("visible", 32'(m_tuser), 32'(want.vis));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("perspective_point_projection verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_VIEW_W)      view_w = longint'(value[SIZE_W-1:0]);
        else if (idx == REG_VIEW_H) view_h = longint'(value[SIZE_W-1:0]);
        else                        row_coef[int'(idx)] = value;
    endtask

    task automatic wait_drained();
        while (pending_points.size() > 0 || s_tvalid || pending_pixels.size() > 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] near_coef();
        return 32'($urandom_range(262143)) - 32'd131072;
    endfunction

    function automatic logic [31:0] extreme_coef();
        case ($urandom_range(3))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            default: return 32'h00010000;
        endcase
    endfunction

    task automatic load_matrix(int kind, logic [63:0] vw, logic [63:0] vh);
        logic [31:0]        hi, lo;
        logic signed [31:0] nc;
        for (int i = 0; i < 6; i++) begin
            case (kind)
                0: begin
                    hi = near_coef();
                    lo = near_coef();
                    if (i == 5) begin
                        nc = $signed(near_coef()) >>> 2;
                        hi = 32'h00010000 + nc;
                    end
                end
                1: begin
                    hi = $urandom;
                    lo = $urandom;
                end
                default: begin
                    hi = extreme_coef();
                    lo = extreme_coef();
                end
            endcase
            write_reg(cfg_index_t'(i), {hi, lo});
        end
        write_reg(REG_VIEW_W, vw);
        write_reg(REG_VIEW_H, vh);
    endtask

    function automatic logic [31:0] pick_coord(bit depth);
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(5))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'hffffffff;
                    4: return 32'd656;
                    default: return 32'd655;
                endcase
            end
            default: begin
                if (depth) return 32'($urandom_range(4194304, 300));
                return 32'($urandom_range(8388607)) - 32'd4194304;
            end
        endcase
    endfunction

    initial begin
        logic [63:0] widths [8];
        logic [63:0] heights [8];
        widths  = '{64'd0, 64'd1, 64'd8192, 64'hffff_ffff_ffff_ffff, 64'd640, 64'd1,
                    64'd8191, 64'd3};
        heights = '{64'd1, 64'd0, 64'd8192, 64'd16383, 64'd480, 64'd1, 64'hc000, 64'd5};
        foreach (row_coef[i]) row_coef[i] = '0;
        view_w = longint'(VIEW_W_RESET);
        view_h = longint'(VIEW_H_RESET);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: zero matrix, every point invisible
        pending_points.push_back('0);
        pending_points.push_back({32'h7fffffff, 32'h80000000, 32'hffffffff});
        pending_points.push_back({32'h80000000, 32'h7fffffff, 32'h00000001});
        wait_drained();

        // plain projection: x, y through, w = z
        write_reg(REG_ROW0_AB, {32'h00010000, 32'h0});
        write_reg(REG_ROW0_CD, 64'h0);
        write_reg(REG_ROW1_AB, {32'h0, 32'h00010000});
        write_reg(REG_ROW1_CD, 64'h0);
        write_reg(REG_ROW3_AB, 64'h0);
        write_reg(REG_ROW3_CD, {32'h00010000, 32'h0});
        write_reg(REG_VIEW_W, 64'd1920);
        write_reg(REG_VIEW_H, 64'd1080);
        pending_points.push_back({32'h00010000, 32'h0, 32'h0});
        pending_points.push_back({32'd656, 32'h00008000, 32'hffff8000});
        pending_points.push_back({32'd655, 32'h00008000, 32'hffff8000});
        pending_points.push_back({32'h0, 32'h00010000, 32'h00010000});
        pending_points.push_back({32'hffff0000, 32'h00010000, 32'h00010000});
        pending_points.push_back({32'h80000000, 32'h00010000, 32'h00010000});
        pending_points.push_back({32'd656, 32'h7fffffff, 32'h80000000});
        pending_points.push_back({32'd656, 32'h80000000, 32'h7fffffff});
        pending_points.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        pending_points.push_back({32'h7fffffff, 32'h80000000, 32'h80000000});
        pending_points.push_back({32'h00020000, 32'hfffe0000, 32'h00030000});
        wait_drained();
        write_reg(REG_VIEW_W, 64'd0);
        write_reg(REG_VIEW_H, 64'd0);
        pending_points.push_back({32'h00010000, 32'h00004000, 32'hffffc000});
        pending_points.push_back({32'd656, 32'h7fffffff, 32'h80000000});
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            load_matrix((ph % 4 == 1) ? 1 : (ph % 4 == 3) ? 2 : 0, widths[ph], heights[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            for (int n = 0; n < 140; n++)
                pending_points.push_back({pick_coord(1'b1), pick_coord(1'b0), pick_coord(1'b0)});
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0)
            $display("perspective_point_projection verification clean");
        else
            $display("perspective_point_projection verification failed");
        $finish;
    end

endmodule
